@@ hw/rtl/sppt_pkg.sv @@
package sppt_pkg;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MUL_AB = 2'd0,  // a[i] * b[j]
        MUL_BA = 2'd1,  // a[j] * b[i]
        MUL_HI = 2'd2,  // cross high slice * p[k]
        MUL_LO = 2'd3   // cross low slice * p[k]
    } t_mul_sel;

    // What to do with the registered product in the cycle after the multiply
    typedef enum logic [2:0] {
        ACC_NONE       = 3'd0,
        ACC_CROSS_LOAD = 3'd1,
        ACC_CROSS_SUB  = 3'd2,
        ACC_HI         = 3'd3,
        ACC_LO         = 3'd4
    } t_acc_mode;

    // Cross product component in work
    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } t_comp;

    // Controller to datapath command
    typedef struct packed {
        logic      load_item;  // latch input beat
        logic      upd_prior;  // prior vertex <= current vertex
        logic      b_start;    // edge end is start vertex, else current vertex
        t_comp     comp;
        t_mul_sel  mul_sel;
        t_acc_mode acc_mode;
        logic      acc_clr;    // first dot product term loads the accumulator
        logic      rec;        // record the edge sign
        logic      rec_close;  // closing edge: also load result, clear polygon state
    } t_dp_cmd;

endpackage

@@ hw/rtl/sppt_dp.sv @@
module sppt_dp #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sppt_pkg::t_dp_cmd            i_cmd,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    input  logic                         i_first_vertex,
    output logic                         o_outside_flag
);
    import sppt_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int M  = N + 1;       // multiplier operand width
    localparam int PW = 2 * M;       // product width
    localparam int CW = 2 * N + 1;   // cross component width
    localparam int AW = 3 * N + 2;   // dot product accumulator width

    logic [2:0][N-1:0] r_start, r_prior, r_cur, r_pt;
    logic signed [PW-1:0] r_prod;
    t_acc_mode            r_mode;
    logic                 r_clr;
    logic signed [CW-1:0] r_cross;
    logic signed [AW-1:0] r_acc;
    logic                 r_have, r_ref, r_mism, r_flag;

    logic [2:0][N-1:0]    b_vec;
    logic [N-1:0]         ai, aj, bi, bj, pk;
    logic signed [M-1:0]  op_a, op_b;
    logic signed [AW-1:0] term;
    logic                 pos, n_have, n_ref, n_mism;

    // Item registers; start and prior are visible after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_prior <= '0;
        end else begin
            if (i_cmd.load_item && i_first_vertex) begin
                r_start <= {i_vertex_z, i_vertex_y, i_vertex_x};
            end
            if (i_cmd.upd_prior) begin
                r_prior <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cur <= {i_vertex_z, i_vertex_y, i_vertex_x};
            r_pt  <= {i_point_z, i_point_y, i_point_x};
        end
    end

    // Operand pick for cross component k = a[i]*b[j] - a[j]*b[i]
    always_comb begin
        b_vec = i_cmd.b_start ? r_start : r_cur;
        unique case (i_cmd.comp)
            COMP_Y: begin
                ai = r_prior[2]; aj = r_prior[0]; bi = b_vec[2]; bj = b_vec[0]; pk = r_pt[1];
            end
            COMP_Z: begin
                ai = r_prior[0]; aj = r_prior[1]; bi = b_vec[0]; bj = b_vec[1]; pk = r_pt[2];
            end
            default: begin
                ai = r_prior[1]; aj = r_prior[2]; bi = b_vec[1]; bj = b_vec[2]; pk = r_pt[0];
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_AB: begin
                op_a = $signed({ai[N-1], ai});
                op_b = $signed({bj[N-1], bj});
            end
            MUL_BA: begin
                op_a = $signed({aj[N-1], aj});
                op_b = $signed({bi[N-1], bi});
            end
            MUL_HI: begin
                op_a = r_cross[CW-1:N];
                op_b = $signed({pk[N-1], pk});
            end
            default: begin
                op_a = $signed({1'b0, r_cross[N-1:0]});
                op_b = $signed({pk[N-1], pk});
            end
        endcase
    end

    // Shared multiplier, product registered with its pending action
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        r_clr  <= i_cmd.acc_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ACC_NONE;
        end else begin
            r_mode <= i_cmd.acc_mode;
        end
    end

    // Cross component and dot product accumulation
    always_comb begin
        if (r_mode == ACC_HI) begin
            term = {r_prod, {N{1'b0}}};
        end else begin
            term = {{N{r_prod[PW-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_mode)
            ACC_CROSS_LOAD: r_cross <= r_prod[CW-1:0];
            ACC_CROSS_SUB:  r_cross <= r_cross - r_prod[CW-1:0];
            ACC_HI, ACC_LO: r_acc   <= r_clr ? term : r_acc + term;
            default: ;
        endcase
    end

    // Edge sign: zero counts as negative
    always_comb begin
        pos = !r_acc[AW-1] && (r_acc != '0);
        if (!r_have) begin
            n_have = 1'b1;
            n_ref  = pos;
            n_mism = r_mism;
        end else begin
            n_have = r_have;
            n_ref  = r_ref;
            n_mism = r_mism | (pos != r_ref);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_ref  <= 1'b0;
            r_mism <= 1'b0;
        end else if (i_cmd.load_item && i_first_vertex) begin
            r_have <= 1'b0;
            r_mism <= 1'b0;
        end else if (i_cmd.rec) begin
            r_ref <= n_ref;
            if (i_cmd.rec_close) begin
                r_have <= 1'b0;
                r_mism <= 1'b0;
            end else begin
                r_have <= n_have;
                r_mism <= n_mism;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec && i_cmd.rec_close) begin
            r_flag <= n_mism;
        end
    end

    assign o_outside_flag = r_flag;

endmodule

@@ hw/rtl/sppt_ctrl.sv @@
module sppt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_first_vertex,
    input  logic              i_last_vertex,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sppt_pkg::t_dp_cmd o_cmd
);
    import sppt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_REC   = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    // Steps of one cross component
    localparam logic [2:0] PH_LOAD = 3'd0;
    localparam logic [2:0] PH_SUB  = 3'd1;
    localparam logic [2:0] PH_WAIT = 3'd2;
    localparam logic [2:0] PH_HI   = 3'd3;
    localparam logic [2:0] PH_LO   = 3'd4;

    t_state     r_state, n_state;
    t_comp      r_comp, n_comp;
    logic [2:0] r_phase, n_phase;
    logic       r_first, n_first;
    logic       r_last, n_last;
    logic       r_closing, n_closing;
    logic       r_out_valid, n_out_valid;
    logic       in_acc, out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_comp      = r_comp;
        n_phase     = r_phase;
        n_first     = r_first;
        n_last      = r_last;
        n_closing   = r_closing;
        n_out_valid = r_out_valid && !i_out_ready;

        o_cmd           = '0;
        o_cmd.comp      = r_comp;
        o_cmd.b_start   = r_closing;
        o_cmd.mul_sel   = MUL_AB;
        o_cmd.acc_mode  = ACC_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load_item = 1'b1;
                    n_first   = i_first_vertex;
                    n_last    = i_last_vertex;
                    n_closing = 1'b0;
                    n_comp    = COMP_X;
                    n_phase   = PH_LOAD;
                    n_state   = i_first_vertex ? S_UPD : S_MUL;
                end
            end
            S_MUL: begin
                unique case (r_phase)
                    PH_LOAD: begin
                        o_cmd.mul_sel  = MUL_AB;
                        o_cmd.acc_mode = ACC_CROSS_LOAD;
                    end
                    PH_SUB: begin
                        o_cmd.mul_sel  = MUL_BA;
                        o_cmd.acc_mode = ACC_CROSS_SUB;
                    end
                    PH_HI: begin
                        o_cmd.mul_sel  = MUL_HI;
                        o_cmd.acc_mode = ACC_HI;
                        o_cmd.acc_clr  = (r_comp == COMP_X);
                    end
                    PH_LO: begin
                        o_cmd.mul_sel  = MUL_LO;
                        o_cmd.acc_mode = ACC_LO;
                    end
                    default: ;  // wait for the cross component to settle
                endcase
                if (r_phase == PH_LO) begin
                    n_phase = PH_LOAD;
                    unique case (r_comp)
                        COMP_X:  n_comp = COMP_Y;
                        COMP_Y:  n_comp = COMP_Z;
                        default: begin
                            n_comp  = COMP_X;
                            n_state = S_DRAIN;
                        end
                    endcase
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_REC;
            end
            S_REC: begin
                if (!r_closing) begin
                    o_cmd.rec = 1'b1;
                    n_state   = S_UPD;
                end else if (out_free) begin
                    o_cmd.rec       = 1'b1;
                    o_cmd.rec_close = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_UPD: begin
                o_cmd.upd_prior = 1'b1;
                if (r_last) begin
                    n_closing = 1'b1;
                    n_comp    = COMP_X;
                    n_phase   = PH_LOAD;
                    n_state   = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_comp      <= COMP_X;
            r_phase     <= PH_LOAD;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
            r_closing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_comp      <= n_comp;
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_last      <= n_last;
            r_closing   <= n_closing;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A beat without first mark starts the edge sequence at its first step
    a_start_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_first_vertex) |=>
            (r_state == S_MUL && r_comp == COMP_X && r_phase == PH_LOAD))
        else $error("edge sequence did not start after beat");

    // A closing record never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_cmd.rec && o_cmd.rec_close))
        else $error("result overwritten");

    // A result appears only out of the closing edge record
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_REC && r_closing))
        else $error("result raised outside closing record");

    // Step counter stays within the component sequence
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_phase <= PH_LO &&
            (r_comp == COMP_X || r_comp == COMP_Y || r_comp == COMP_Z)))
        else $error("step counter out of range");

    // Closing edge only follows a beat with last mark
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_closing && r_state == S_MUL) |-> r_last)
        else $error("closing edge without last mark");

    // No open edge runs on a first-marked beat
    a_first_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !r_closing) |-> !r_first)
        else $error("open edge run on a first vertex beat");

endmodule

@@ hw/rtl/spherical_polygon_point_test_core.sv @@
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     point xyz, vertex xyz, first, last marks
// output    o_out_valid / i_out_ready   outside flag, one beat per last-marked vertex
//
// A beat is taken only while the controller is idle; one shared 25x25 multiplier
// (COORD_BITS+1 square) forms each edge test in 15 steps, then drains and records.
// A first-marked beat runs no edge test; a last-marked beat adds the closing edge.
// Reset clears the polygon state (start and prior vertex to zero), not the outside flag.
// A waiting result does not block the next beat; only a second closing edge
// waits for the output register to empty.
module spherical_polygon_point_test_core #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    input  logic                         i_first_vertex,
    input  logic                         i_last_vertex,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_outside_flag
);
    import sppt_pkg::*;

    t_dp_cmd cmd;

    // Sequencer
    sppt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_vertex (i_first_vertex),
        .i_last_vertex  (i_last_vertex),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cmd          (cmd)
    );

    // Edge arithmetic and polygon state
    sppt_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_vertex_z     (i_vertex_z),
        .i_first_vertex (i_first_vertex),
        .o_outside_flag (o_outside_flag)
    );

endmodule
